/* rtl/tmr_pkg.sv */
package tmr_pkg;

    localparam int MAX_SIDE_DEF  = 64;
    localparam int MAX_STEPS_DEF = 2000;

    localparam int FRAC_W      = 16;
    localparam int POS_W       = 25;   // signed Q8.16, room for origin plus any march
    localparam int ORIGIN_W    = 22;
    localparam int STEP_W      = 11;
    localparam int MAP_REG_W   = 7;
    localparam int LIM_W       = 9;
    localparam int COORD_W     = POS_W - 1 - FRAC_W;
    localparam int KIND_W      = 4;
    localparam int WIDTH_W     = 17;
    localparam int STEPS_OUT_W = 11;
    localparam int CFG_IDX_W   = 1;

    localparam logic [WIDTH_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [WIDTH_W-1:0] HALF_Q16 = 17'd32768;
    localparam logic [WIDTH_W-1:0] DOOR_TOL = 17'd1310;

    localparam logic [KIND_W-1:0] CODE_OPEN    = 4'd0;
    localparam logic [KIND_W-1:0] CODE_WALL_LO = 4'd1;
    localparam logic [KIND_W-1:0] CODE_WALL_HI = 4'd10;
    localparam logic [KIND_W-1:0] CODE_OOB     = 4'd2;
    localparam logic [KIND_W-1:0] CODE_HDOOR   = 4'd11;
    localparam logic [KIND_W-1:0] CODE_VDOOR   = 4'd12;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        REQ_TILE = 2'd0,
        REQ_DOOR = 2'd1,
        REQ_CAST = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_MARCH
    } state_t;

    typedef struct packed {
        logic                stop;
        logic [KIND_W-1:0]   kind;
        logic [FRAC_W-1:0]   tex;
    } probe_res_t;

    // distance of a fraction to the nearest integer
    function automatic logic [WIDTH_W-1:0] near_int_dist(input logic [FRAC_W-1:0] f);
        logic [WIDTH_W-1:0] fe;
        logic [WIDTH_W-1:0] g;
        fe = {1'b0, f};
        g  = ONE_Q16 - fe;
        return (fe < g) ? fe : g;
    endfunction

    // true when the point is off the door's centre line by more than the tolerance
    function automatic logic off_centre(input logic [WIDTH_W-1:0] d);
        logic [WIDTH_W-1:0] diff;
        diff = (d > HALF_Q16) ? (d - HALF_Q16) : (HALF_Q16 - d);
        return diff > DOOR_TOL;
    endfunction

endpackage

/* rtl/tmr_store.sv */
module tmr_store #(
    parameter int MAX_SIDE = tmr_pkg::MAX_SIDE_DEF,
    localparam int DEPTH   = MAX_SIDE * MAX_SIDE,
    localparam int ADDR_W  = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_tile,
    input  logic                        wr_door,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [tmr_pkg::KIND_W-1:0]  wr_code,
    input  logic [tmr_pkg::WIDTH_W-1:0] wr_width,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [tmr_pkg::KIND_W-1:0]  rd_code,
    output logic [tmr_pkg::WIDTH_W-1:0] rd_width
);

    logic [tmr_pkg::KIND_W-1:0]  tile_mem [DEPTH];
    logic [tmr_pkg::WIDTH_W-1:0] door_mem [DEPTH];
    logic [tmr_pkg::KIND_W-1:0]  rd_code_reg;
    logic [tmr_pkg::WIDTH_W-1:0] rd_width_reg;

    always_ff @(posedge clk)
    begin
        if (wr_tile)
        begin
            tile_mem[wr_addr] <= wr_code;
        end
        rd_code_reg <= tile_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_door)
        begin
            door_mem[wr_addr] <= wr_width;
        end
        rd_width_reg <= door_mem[rd_addr];
    end

    assign rd_code  = rd_code_reg;
    assign rd_width = rd_width_reg;

endmodule

/* rtl/tmr_probe.sv */
module tmr_probe (
    input  logic                        in_map,
    input  logic [tmr_pkg::KIND_W-1:0]  code,
    input  logic [tmr_pkg::WIDTH_W-1:0] open_width,
    input  logic [tmr_pkg::FRAC_W-1:0]  frac_x,
    input  logic [tmr_pkg::FRAC_W-1:0]  frac_y,
    output tmr_pkg::probe_res_t         res
);

    logic [tmr_pkg::WIDTH_W-1:0] dist_x;
    logic [tmr_pkg::WIDTH_W-1:0] dist_y;
    logic [tmr_pkg::FRAC_W-1:0]  along;
    logic [tmr_pkg::WIDTH_W-1:0] door_tex;

    assign dist_x = tmr_pkg::near_int_dist(frac_x);
    assign dist_y = tmr_pkg::near_int_dist(frac_y);

    // horizontal door runs along x, vertical along y
    assign along    = (code == tmr_pkg::CODE_HDOOR) ? frac_x : frac_y;
    assign door_tex = tmr_pkg::ONE_Q16 - open_width + {1'b0, along};

    always_comb
    begin
        res.stop = 1'b0;
        res.kind = tmr_pkg::CODE_OPEN;
        res.tex  = '0;
        if (!in_map)
        begin
            res.stop = 1'b1;
            res.kind = tmr_pkg::CODE_OOB;
        end
        else if (code inside {[tmr_pkg::CODE_WALL_LO:tmr_pkg::CODE_WALL_HI]})
        begin
            res.stop = 1'b1;
            res.kind = code;
            res.tex  = (dist_x >= dist_y) ? frac_x : frac_y;
        end
        else if (code == tmr_pkg::CODE_HDOOR)
        begin
            if (!tmr_pkg::off_centre(dist_y) && ({1'b0, frac_x} < open_width))
            begin
                res.stop = 1'b1;
                res.kind = code;
                res.tex  = door_tex[tmr_pkg::FRAC_W-1:0];
            end
        end
        else if (code == tmr_pkg::CODE_VDOOR)
        begin
            if (!tmr_pkg::off_centre(dist_x) && ({1'b0, frac_y} < open_width))
            begin
                res.stop = 1'b1;
                res.kind = code;
                res.tex  = door_tex[tmr_pkg::FRAC_W-1:0];
            end
        end
    end

endmodule

/* rtl/tile_map_ray_marcher.sv */
// Tile-map ray marcher. Tile and door-width writes are taken while idle and
// their all-zero result appears on the next cycle. A cast probes at most
// MAX_STEPS steps: the prime state starts the tile store read, then the march
// state probes the steps in turn through the single registered read port of
// the tile store and the position adders. done pulses for one cycle with the
// result; there is no back-pressure, so the receiver must take it then. busy
// is low again in the cycle done is shown, so a new request may be started
// there. Table entries must be written before a cast reads them.
module tile_map_ray_marcher #(
    parameter int MAX_SIDE  = tmr_pkg::MAX_SIDE_DEF,
    parameter int MAX_STEPS = tmr_pkg::MAX_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [tmr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmr_pkg::MAP_REG_W-1:0]      cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         req_type,
    input  logic [5:0]                         tile_col,
    input  logic [5:0]                         tile_row,
    input  logic [tmr_pkg::KIND_W-1:0]         tile_code,
    input  logic [tmr_pkg::WIDTH_W-1:0]        door_open_width,
    input  logic [tmr_pkg::ORIGIN_W-1:0]       origin_x,
    input  logic [tmr_pkg::ORIGIN_W-1:0]       origin_y,
    input  logic signed [tmr_pkg::STEP_W-1:0]  step_x,
    input  logic signed [tmr_pkg::STEP_W-1:0]  step_y,
    output logic                               done,
    output logic                               hit,
    output logic [tmr_pkg::KIND_W-1:0]         hit_kind,
    output logic [tmr_pkg::STEPS_OUT_W-1:0]    steps_taken,
    output logic [tmr_pkg::FRAC_W-1:0]         texture_offset
);

    localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int CNT_W  = $clog2(MAX_STEPS + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAX_STEPS - 1);
    localparam logic [CNT_W-1:0] ALL_STEPS = CNT_W'(MAX_STEPS);
    localparam int POS_W  = tmr_pkg::POS_W;
    localparam int FRAC_W = tmr_pkg::FRAC_W;
    localparam int LIM_W  = tmr_pkg::LIM_W;

    tmr_pkg::state_t state_reg, state_next;
    tmr_pkg::req_t   req;

    logic [tmr_pkg::MAP_REG_W-1:0] map_w_reg, map_h_reg;
    logic signed [POS_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic signed [tmr_pkg::STEP_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     in_map_reg, in_map_next;

    logic                                done_reg, done_next;
    logic                                hit_reg, hit_next;
    logic [tmr_pkg::KIND_W-1:0]          kind_reg, kind_next;
    logic [tmr_pkg::STEPS_OUT_W-1:0]     steps_reg, steps_next;
    logic [tmr_pkg::FRAC_W-1:0]          tex_reg, tex_next;

    logic                     accept;
    logic signed [POS_W-1:0]  nx, ny;
    logic [tmr_pkg::COORD_W-1:0] ncol, nrow;
    logic [LIM_W-1:0]         lim_w, lim_h;
    logic                     n_in_map;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_in_store;
    logic                     wr_tile, wr_door;
    logic [ADDR_W-1:0]        wr_addr;
    logic [tmr_pkg::WIDTH_W-1:0] wr_width;
    logic [tmr_pkg::KIND_W-1:0]  rd_code;
    logic [tmr_pkg::WIDTH_W-1:0] rd_width;
    tmr_pkg::probe_res_t      probe;

    assign busy   = (state_reg != tmr_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign req    = tmr_pkg::req_t'(req_type);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg <= 7'd64;
            map_h_reg <= 7'd64;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tmr_pkg::CFG_MAP_WIDTH:  map_w_reg <= cfg_data;
                tmr_pkg::CFG_MAP_HEIGHT: map_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign lim_w = ({2'b00, map_w_reg} > LIM_W'(MAX_SIDE)) ? LIM_W'(MAX_SIDE)
                                                         : {2'b00, map_w_reg};
    assign lim_h = ({2'b00, map_h_reg} > LIM_W'(MAX_SIDE)) ? LIM_W'(MAX_SIDE)
                                                         : {2'b00, map_h_reg};

    // next point of the march and its tile address
    assign nx   = px_reg + POS_W'(sx_reg);
    assign ny   = py_reg + POS_W'(sy_reg);
    assign ncol = nx[POS_W-2:FRAC_W];
    assign nrow = ny[POS_W-2:FRAC_W];
    assign n_in_map = !nx[POS_W-1] && !ny[POS_W-1]
                      && (LIM_W'(ncol) < lim_w) && (LIM_W'(nrow) < lim_h);
    assign rd_addr  = n_in_map ? (ADDR_W'(nrow) * ADDR_W'(MAX_SIDE) + ADDR_W'(ncol))
                               : '0;

    // table writes
    assign wr_in_store = (LIM_W'(tile_col) < LIM_W'(MAX_SIDE))
                         && (LIM_W'(tile_row) < LIM_W'(MAX_SIDE));
    assign wr_addr  = ADDR_W'(tile_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(tile_col);
    assign wr_tile  = accept && (req == tmr_pkg::REQ_TILE) && wr_in_store;
    assign wr_door  = accept && (req == tmr_pkg::REQ_DOOR) && wr_in_store;
    assign wr_width = (door_open_width > tmr_pkg::ONE_Q16) ? tmr_pkg::ONE_Q16
                                                           : door_open_width;

    tmr_store #(
        .MAX_SIDE (MAX_SIDE)
    ) u_store (
        .clk      (clk),
        .wr_tile  (wr_tile),
        .wr_door  (wr_door),
        .wr_addr  (wr_addr),
        .wr_code  (tile_code),
        .wr_width (wr_width),
        .rd_addr  (rd_addr),
        .rd_code  (rd_code),
        .rd_width (rd_width)
    );

    // probes the point whose tile data has just come out of the store
    tmr_probe u_probe (
        .in_map     (in_map_reg),
        .code       (rd_code),
        .open_width (rd_width),
        .frac_x     (px_reg[FRAC_W-1:0]),
        .frac_y     (py_reg[FRAC_W-1:0]),
        .res        (probe)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmr_pkg::ST_IDLE:
            begin
                if (accept && (req == tmr_pkg::REQ_CAST))
                begin
                    state_next = tmr_pkg::ST_PRIME;
                end
            end
            tmr_pkg::ST_PRIME:
            begin
                state_next = tmr_pkg::ST_MARCH;
            end
            tmr_pkg::ST_MARCH:
            begin
                if (probe.stop || (cnt_reg == LAST_STEP))
                begin
                    state_next = tmr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmr_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        px_next     = px_reg;
        py_next     = py_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        cnt_next    = cnt_reg;
        in_map_next = in_map_reg;
        done_next   = 1'b0;
        hit_next    = 1'b0;
        kind_next   = tmr_pkg::CODE_OPEN;
        steps_next  = '0;
        tex_next    = '0;
        case (state_reg)
            tmr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // writes and unused requests answer with an all-zero transfer
                    done_next = (req != tmr_pkg::REQ_CAST);
                    px_next   = POS_W'(origin_x);
                    py_next   = POS_W'(origin_y);
                    sx_next   = step_x;
                    sy_next   = step_y;
                    cnt_next  = '0;
                end
            end
            tmr_pkg::ST_PRIME:
            begin
                px_next     = nx;
                py_next     = ny;
                in_map_next = n_in_map;
            end
            tmr_pkg::ST_MARCH:
            begin
                px_next     = nx;
                py_next     = ny;
                in_map_next = n_in_map;
                cnt_next    = cnt_reg + 1'b1;
                if (probe.stop)
                begin
                    done_next  = 1'b1;
                    hit_next   = 1'b1;
                    kind_next  = probe.kind;
                    steps_next = tmr_pkg::STEPS_OUT_W'(cnt_reg);
                    tex_next   = probe.tex;
                end
                else if (cnt_reg == LAST_STEP)
                begin
                    done_next  = 1'b1;
                    steps_next = tmr_pkg::STEPS_OUT_W'(ALL_STEPS);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmr_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        cnt_reg    <= cnt_next;
        in_map_reg <= in_map_next;
        hit_reg    <= hit_next;
        kind_reg   <= kind_next;
        steps_reg  <= steps_next;
        tex_reg    <= tex_next;
    end

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign hit_kind       = kind_reg;
    assign steps_taken    = steps_reg;
    assign texture_offset = tex_reg;

endmodule

/* dv/tmr_checker.sv */
module tmr_checker
    import tmr_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [MAP_REG_W-1:0]      cfg_data,
    input  logic                      start,
    input  logic                      busy,
    input  logic [1:0]                req_type,
    input  logic [5:0]                tile_col,
    input  logic [5:0]                tile_row,
    input  logic [KIND_W-1:0]         tile_code,
    input  logic [WIDTH_W-1:0]        door_open_width,
    input  logic [ORIGIN_W-1:0]       origin_x,
    input  logic [ORIGIN_W-1:0]       origin_y,
    input  logic signed [STEP_W-1:0]  step_x,
    input  logic signed [STEP_W-1:0]  step_y,
    input  logic                      done,
    input  logic                      hit,
    input  logic [KIND_W-1:0]         hit_kind,
    input  logic [STEPS_OUT_W-1:0]    steps_taken,
    input  logic [FRAC_W-1:0]         texture_offset,
    output int                        fails,
    output int                        waiting
);

    localparam int SIDE  = MAX_SIDE_DEF;
    localparam int STEPS = MAX_STEPS_DEF;

    typedef struct packed {
        logic                   hit;
        logic [KIND_W-1:0]      kind;
        logic [STEPS_OUT_W-1:0] steps;
        logic [FRAC_W-1:0]      tex;
    } ray_outcome_t;

    logic [KIND_W-1:0]    tile_map [0:SIDE*SIDE-1];
    logic [WIDTH_W-1:0]   width_table [0:SIDE*SIDE-1];
    logic [MAP_REG_W-1:0] cols_in_use;
    logic [MAP_REG_W-1:0] rows_in_use;
    ray_outcome_t         ray_outcomes [$];
    int                   miss_count;
    int                   outcomes_due;

    assign fails   = miss_count;
    assign waiting = outcomes_due;

    task automatic report(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        miss_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    // distance of a Q16 fraction to the nearest integer
    function automatic int frac_gap(input int f);
        int g;
        g = int'(ONE_Q16) - f;
        return (f < g) ? f : g;
    endfunction

    function automatic int centre_miss(input int d);
        return (d > int'(HALF_Q16)) ? d - int'(HALF_Q16) : int'(HALF_Q16) - d;
    endfunction

    // does the point stop the ray; kind and tex are valid only when it does
    function automatic bit tile_stop(input int px, input int py,
                                     output logic [KIND_W-1:0] kind,
                                     output logic [FRAC_W-1:0] tex);
        int col, row, lim_c, lim_r, idx, fx, fy, w, t;
        logic [KIND_W-1:0] code;
        kind = CODE_OPEN;
        tex  = '0;
        if (px < 0 || py < 0)
        begin
            kind = CODE_OOB;
            return 1'b1;
        end
        col   = px >>> FRAC_W;
        row   = py >>> FRAC_W;
        lim_c = (cols_in_use > SIDE) ? SIDE : int'(cols_in_use);
        lim_r = (rows_in_use > SIDE) ? SIDE : int'(rows_in_use);
        if (col >= lim_c || row >= lim_r)
        begin
            kind = CODE_OOB;
            return 1'b1;
        end
        idx  = row * SIDE + col;
        code = tile_map[idx];
        fx   = px & 32'hFFFF;
        fy   = py & 32'hFFFF;
        if (code >= CODE_WALL_LO && code <= CODE_WALL_HI)
        begin
            kind = code;
            t    = (frac_gap(fx) >= frac_gap(fy)) ? fx : fy;
            tex  = t[FRAC_W-1:0];
            return 1'b1;
        end
        w = int'(width_table[idx]);
        if (code == CODE_HDOOR)
        begin
            if (centre_miss(frac_gap(fy)) > int'(DOOR_TOL) || fx >= w)
                return 1'b0;
            kind = code;
            t    = int'(ONE_Q16) - w + fx;
            tex  = t[FRAC_W-1:0];
            return 1'b1;
        end
        if (code == CODE_VDOOR)
        begin
            if (centre_miss(frac_gap(fx)) > int'(DOOR_TOL) || fy >= w)
                return 1'b0;
            kind = code;
            t    = int'(ONE_Q16) - w + fy;
            tex  = t[FRAC_W-1:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic ray_outcome_t march_ray(input logic [ORIGIN_W-1:0] ox,
                                               input logic [ORIGIN_W-1:0] oy,
                                               input logic signed [STEP_W-1:0] sx,
                                               input logic signed [STEP_W-1:0] sy);
        ray_outcome_t res;
        int px, py, dx, dy, n;
        logic [KIND_W-1:0] kind;
        logic [FRAC_W-1:0] tex;
        res = '0;
        px  = int'(ox);
        py  = int'(oy);
        dx  = int'(sx);
        dy  = int'(sy);
        for (n = 0; n < STEPS; n++)
        begin
            if (tile_stop(px + dx, py + dy, kind, tex))
            begin
                res.hit   = 1'b1;
                res.kind  = kind;
                res.steps = STEPS_OUT_W'(n);
                res.tex   = tex;
                return res;
            end
            px += dx;
            py += dy;
        end
        res.steps = STEPS_OUT_W'(STEPS);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ray_outcome_t want;
        ray_outcome_t pred;
        logic [WIDTH_W-1:0] w;
        if (!rst_n)
        begin
            cols_in_use = 7'd64;
            rows_in_use = 7'd64;
            ray_outcomes.delete();
            outcomes_due = 0;
        end
        else
        begin
            if (done)
            begin
                if (ray_outcomes.size() == 0)
                begin
                    report($sformatf("result with nothing outstanding (kind %0d)", hit_kind));
                end
                else
                begin
                    want = ray_outcomes.pop_front();
                    check_field("hit", 16'(hit), 16'(want.hit));
                    check_field("hit_kind", 16'(hit_kind), 16'(want.kind));
                    check_field("steps_taken", 16'(steps_taken), 16'(want.steps));
                    check_field("texture_offset", texture_offset, want.tex);
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_MAP_WIDTH)
                    cols_in_use = cfg_data;
                else if (cfg_index == CFG_MAP_HEIGHT)
                    rows_in_use = cfg_data;
            end
            if (start && !busy)
            begin
                pred = '0;
                case (req_t'(req_type))
                    REQ_TILE: tile_map[{tile_row, tile_col}] = tile_code;
                    REQ_DOOR:
                    begin
                        w = door_open_width;
                        width_table[{tile_row, tile_col}] = (w > ONE_Q16) ? ONE_Q16 : w;
                    end
                    REQ_CAST: pred = march_ray(origin_x, origin_y, step_x, step_y);
                    default: ;
                endcase
                ray_outcomes.push_back(pred);
            end
            outcomes_due = ray_outcomes.size();
        end
    end

    initial miss_count = 0;

endmodule

/* dv/tb.sv */
module tb;
    import tmr_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int Q = 65536;
    // cast origins stay below REGION unless the map side is at most REGION; a ring of walls sits at REGION
    localparam int REGION = 8;

    typedef struct {
        req_t                req;
        logic [5:0]          col;
        logic [5:0]          row;
        logic [KIND_W-1:0]   code;
        logic [WIDTH_W-1:0]  width;
        logic [ORIGIN_W-1:0] ox;
        logic [ORIGIN_W-1:0] oy;
        logic [STEP_W-1:0]   sx;
        logic [STEP_W-1:0]   sy;
    } request_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [MAP_REG_W-1:0]      cfg_data;
    logic                      start;
    logic                      busy;
    logic [1:0]                req_type;
    logic [5:0]                tile_col;
    logic [5:0]                tile_row;
    logic [KIND_W-1:0]         tile_code;
    logic [WIDTH_W-1:0]        door_open_width;
    logic [ORIGIN_W-1:0]       origin_x;
    logic [ORIGIN_W-1:0]       origin_y;
    logic signed [STEP_W-1:0]  step_x;
    logic signed [STEP_W-1:0]  step_y;
    logic                      done;
    logic                      hit;
    logic [KIND_W-1:0]         hit_kind;
    logic [STEPS_OUT_W-1:0]    steps_taken;
    logic [FRAC_W-1:0]         texture_offset;

    int fails;
    int waiting;
    int idle_cycles;
    int cols_cfg;
    int rows_cfg;
    bit no_gaps;

    tile_map_ray_marcher u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .req_type(req_type), .tile_col(tile_col), .tile_row(tile_row),
        .tile_code(tile_code), .door_open_width(door_open_width),
        .origin_x(origin_x), .origin_y(origin_y), .step_x(step_x), .step_y(step_y),
        .done(done), .hit(hit), .hit_kind(hit_kind), .steps_taken(steps_taken),
        .texture_offset(texture_offset)
    );

    tmr_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .req_type(req_type), .tile_col(tile_col), .tile_row(tile_row),
        .tile_code(tile_code), .door_open_width(door_open_width),
        .origin_x(origin_x), .origin_y(origin_y), .step_x(step_x), .step_y(step_y),
        .done(done), .hit(hit), .hit_kind(hit_kind), .steps_taken(steps_taken),
        .texture_offset(texture_offset),
        .fails(fails), .waiting(waiting)
    );

    always #5 clk = ~clk;

    // stall watchdog: no transfer on either side for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // unused fields carry random noise
    function automatic request_t noise_req(input req_t req);
        request_t r;
        r.req   = req;
        r.col   = 6'($urandom_range(0, 63));
        r.row   = 6'($urandom_range(0, 63));
        r.code  = KIND_W'($urandom_range(0, 15));
        r.width = WIDTH_W'($urandom_range(0, 131071));
        r.ox    = ORIGIN_W'($urandom);
        r.oy    = ORIGIN_W'($urandom);
        r.sx    = STEP_W'($urandom);
        r.sy    = STEP_W'($urandom);
        return r;
    endfunction

    function automatic request_t tile_req(input int col, input int row,
                                          input logic [KIND_W-1:0] code);
        request_t r;
        r      = noise_req(REQ_TILE);
        r.col  = 6'(col);
        r.row  = 6'(row);
        r.code = code;
        return r;
    endfunction

    function automatic request_t door_req(input int col, input int row, input int width);
        request_t r;
        r       = noise_req(REQ_DOOR);
        r.col   = 6'(col);
        r.row   = 6'(row);
        r.width = WIDTH_W'(width);
        return r;
    endfunction

    function automatic request_t cast_req(input int ox, input int oy,
                                          input int sx, input int sy);
        request_t r;
        r    = noise_req(REQ_CAST);
        r.ox = ORIGIN_W'(ox);
        r.oy = ORIGIN_W'(oy);
        r.sx = STEP_W'(sx);
        r.sy = STEP_W'(sy);
        return r;
    endfunction

    function automatic int rand_step();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return int'($urandom_range(0, 1312)) - 656;
        else if (sel < 8)
            return int'($urandom_range(0, 2047)) - 1024;
        else
            return int'($urandom_range(0, 14)) - 7;
    endfunction

    // a map no wider than the walled area may take any origin; otherwise stay inside it
    function automatic int rand_origin(input int tiles);
        if (tiles <= REGION && $urandom_range(0, 9) < 2)
            return int'($urandom_range(0, 4194303));
        return int'($urandom_range(0, REGION * Q - 1));
    endfunction

    function automatic logic [KIND_W-1:0] rand_code();
        int p;
        p = $urandom_range(0, 99);
        if (p < 62)
            return CODE_OPEN;
        else if (p < 66)
            return KIND_W'($urandom_range(13, 15));
        else if (p < 80)
            return KIND_W'($urandom_range(CODE_WALL_LO, CODE_WALL_HI));
        else if (p < 90)
            return CODE_HDOOR;
        return CODE_VDOOR;
    endfunction

    function automatic int rand_width();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7)
            return int'($urandom_range(0, 65536));
        else if (p < 8)
            return 65536;
        return int'($urandom_range(0, 131071));
    endfunction

    function automatic request_t rand_req();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70)
            return cast_req(rand_origin(cols_cfg), rand_origin(rows_cfg),
                            rand_step(), rand_step());
        else if (p < 82)
            return tile_req($urandom_range(0, REGION - 1), $urandom_range(0, REGION - 1),
                            rand_code());
        else if (p < 94)
            return door_req($urandom_range(0, 63), $urandom_range(0, 63), rand_width());
        return noise_req(REQ_NONE);
    endfunction

    // one transfer on the request side, after a random gap unless no_gaps is set
    task automatic send(input request_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_type        <= r.req;
        tile_col        <= r.col;
        tile_row        <= r.row;
        tile_code       <= r.code;
        door_open_width <= r.width;
        origin_x        <= r.ox;
        origin_y        <= r.oy;
        step_x          <= r.sx;
        step_y          <= r.sy;
        start           <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (waiting != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= MAP_REG_W'(val);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 16 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send(rand_req());
        end
    endtask

    task automatic set_map(input int w, input int h);
        settle();
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        cols_cfg = w;
        rows_cfg = h;
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        start           = 1'b0;
        req_type        = '0;
        tile_col        = '0;
        tile_row        = '0;
        tile_code       = '0;
        door_open_width = '0;
        origin_x        = '0;
        origin_y        = '0;
        step_x          = '0;
        step_y          = '0;
        cols_cfg        = 64;
        rows_cfg        = 64;
        no_gaps         = 1'b1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // fill the cast area and its wall ring before any cast reads them
        for (int r = 0; r <= REGION; r++)
        begin
            for (int c = 0; c <= REGION; c++)
            begin
                send(door_req(c, r, rand_width()));
                if (r == REGION || c == REGION)
                    send(tile_req(c, r, KIND_W'($urandom_range(CODE_WALL_LO, CODE_WALL_HI))));
                else
                    send(tile_req(c, r, rand_code()));
            end
        end

        no_gaps = 1'b0;
        // directed
        send(tile_req(3, 3, CODE_OPEN));
        send(cast_req(3 * Q + Q / 2, 3 * Q + Q / 2, 0, 0));            // never hits
        send(tile_req(0, 0, CODE_WALL_LO));
        send(cast_req(100, 100, -1024, 0));                           // goes negative
        send(tile_req(6, 0, CODE_OPEN));
        send(tile_req(7, 0, CODE_WALL_HI));
        send(cast_req(6 * Q + Q / 2, Q / 2, 656, 0));                 // wall, digit ten
        send(tile_req(7, 7, 4'd15));                                  // unused code
        send(cast_req(7 * Q + Q / 2, 7 * Q + Q / 2, 656, 0));
        send(tile_req(5, 4, CODE_OPEN));
        send(door_req(5, 5, 131071));                                 // saturates
        send(tile_req(5, 5, CODE_HDOOR));
        send(cast_req(5 * Q + Q / 4, 4 * Q + 58982, 0, 656));
        send(door_req(6, 5, 0));                                      // fully open
        send(tile_req(6, 5, CODE_VDOOR));
        send(cast_req(6 * Q + 6554, 5 * Q + Q / 4, 656, 0));
        send(door_req(7, 5, 65536));
        send(tile_req(7, 5, CODE_VDOOR));
        send(cast_req(7 * Q + 13107, 5 * Q + 19661, 656, 0));
        send(noise_req(REQ_NONE));
        send(cast_req(4 * Q, 4 * Q, -1024, -1024));
        send(cast_req(2 * Q + 123, 2 * Q + 4567, -656, 656));
        send(door_req(0, 7, 1));
        send(tile_req(0, 7, CODE_VDOOR));
        send(cast_req(Q / 3, 6 * Q + Q / 2, 0, 656));

        random_run(34);
        set_map(127, 127);
        random_run(16);
        set_map(1, 64);
        random_run(16);
        set_map(64, 1);
        random_run(16);
        set_map(0, $urandom_range(1, 127));
        random_run(16);
        set_map($urandom_range(1, 127), $urandom_range(1, 127));
        random_run(16);

        settle();
        repeat (20) @(posedge clk);
        if (fails == 0 && waiting == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
